// ===== rtl/core/imuoc_pkg.sv =====
`default_nettype none

package imuoc_pkg;

    localparam int DATA_W       = 16;
    localparam int AXES         = 6;
    localparam int AXIS_W       = 3;
    localparam int ACCEL_Z_AXIS = 2;

    localparam int CAL_W     = 10;
    localparam int GRAV_W    = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 1'd1;

    localparam logic [CAL_W-1:0]  CAL_RESET  = 10'd500;
    localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd4096;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
    localparam logic [AXIS_W-1:0] Z_AXIS    = AXIS_W'(ACCEL_Z_AXIS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/imu_offset_calibrate_correct_top.sv =====
`default_nettype none

// Six-axis IMU offset calibration and correction. After reset the first
// cal_samples words (0 counts as 1, clamped to 2^COUNT_BITS-1) are only summed
// per axis and produce no output; at the last of them each offset becomes the
// sum divided by the sample count, truncated toward zero, with gravity_counts
// taken off the accel z offset (16-bit wrap). Every later word yields the six
// axes minus their offsets, saturated to signed 16 bits. One shared adder walks
// the six axes in turn after a word is accepted. The last calibration word adds
// six passes through a bit-serial divider. A corrected word waits before its
// first axis while the previous result is still held on the output.
// Configuration writes have no effect on offsets once calibration is done.
module imu_offset_calibrate_correct_top #(
    parameter int COUNT_BITS = 10
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_wr_en,
    input  wire logic [imuoc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [imuoc_pkg::CFG_W-1:0]          cfg_wr_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_accel_x,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_accel_y,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_accel_z,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_gyro_x,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_gyro_y,
    input  wire logic signed [imuoc_pkg::DATA_W-1:0]  s_gyro_z,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_accel_x,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_accel_y,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_accel_z,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_gyro_x,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_gyro_y,
    output logic signed [imuoc_pkg::DATA_W-1:0]       m_corr_gyro_z
);
    import imuoc_pkg::*;

    localparam int SUM_W = DATA_W + COUNT_BITS;
    localparam int CMP_W = (COUNT_BITS + 1 > CAL_W) ? COUNT_BITS + 1 : CAL_W;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'((33'd1 << COUNT_BITS) - 33'd1);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_ACCUM     = 6'b000010,
        ST_DIV_START = 6'b000100,
        ST_DIV_WAIT  = 6'b001000,
        ST_OFFSET    = 6'b010000,
        ST_CORRECT   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [AXIS_W-1:0]       axis_reg, axis_next;
    logic                    calibrated_reg, calibrated_next;
    logic [COUNT_BITS-1:0]   samples_seen_reg, samples_seen_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CAL_W-1:0]        cal_reg;
    logic [GRAV_W-1:0]       grav_reg;

    logic signed [DATA_W-1:0] sample_reg [AXES];
    logic signed [SUM_W-1:0]  sum_reg    [AXES];
    logic signed [DATA_W-1:0] offset_reg [AXES];
    logic signed [DATA_W-1:0] out_reg    [AXES];

    logic                    s_fire, out_free, last_axis;
    logic                    accum_we, offset_we, corr_we, div_start;
    logic signed [SUM_W-1:0] alu_a, alu_b, alu_res;
    logic                    alu_sub;
    logic signed [DATA_W-1:0] sat_res;
    logic [COUNT_BITS:0]     taken;
    logic [CMP_W-1:0]        target, taken_ext;
    logic signed [SUM_W-1:0] quotient;
    div_stat_t               div_stat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_axis = (axis_reg == LAST_AXIS);

    // sample count target: zero means one, clamp to the counter range
    always_comb begin
        target = CMP_W'(cal_reg);
        if (cal_reg == '0) begin
            target = CMP_W'(1);
        end
        if (target > LIMIT) begin
            target = LIMIT;
        end
    end

    assign taken     = {1'b0, samples_seen_reg} + (COUNT_BITS + 1)'(1);
    assign taken_ext = CMP_W'(taken);

    // shared adder
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    always_comb begin
        if ((&alu_res[SUM_W-1:DATA_W-1]) || !(|alu_res[SUM_W-1:DATA_W-1])) begin
            sat_res = alu_res[DATA_W-1:0];
        end else begin
            sat_res = alu_res[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_comb begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        calibrated_next   = calibrated_reg;
        samples_seen_next = samples_seen_reg;
        alu_a             = SUM_W'(sample_reg[axis_reg]);
        alu_b             = SUM_W'(offset_reg[axis_reg]);
        alu_sub           = 1'b1;
        accum_we          = 1'b0;
        offset_we         = 1'b0;
        corr_we           = 1'b0;
        div_start         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    axis_next  = '0;
                    state_next = calibrated_reg ? ST_CORRECT : ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                alu_a    = sum_reg[axis_reg];
                alu_b    = SUM_W'(sample_reg[axis_reg]);
                alu_sub  = 1'b0;
                accum_we = 1'b1;
                if (last_axis) begin
                    samples_seen_next = taken[COUNT_BITS-1:0];
                    axis_next         = '0;
                    state_next        = (taken_ext >= target) ? ST_DIV_START : ST_IDLE;
                end else begin
                    axis_next = axis_reg + AXIS_W'(1);
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                // gravity only comes off the vertical accel axis
                alu_a     = quotient;
                alu_b     = (axis_reg == Z_AXIS) ? SUM_W'(grav_reg) : '0;
                offset_we = 1'b1;
                if (last_axis) begin
                    calibrated_next = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_DIV_START;
                end
            end
            ST_CORRECT: begin
                // hold off until the previous word has left the output
                if (out_free) begin
                    corr_we = 1'b1;
                    if (last_axis) begin
                        state_next = ST_IDLE;
                    end else begin
                        axis_next = axis_reg + AXIS_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (corr_we && last_axis) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            axis_reg         <= '0;
            calibrated_reg   <= 1'b0;
            samples_seen_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            axis_reg         <= axis_next;
            calibrated_reg   <= calibrated_next;
            samples_seen_reg <= samples_seen_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg  <= CAL_RESET;
            grav_reg <= GRAV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CAL_SAMPLES: cal_reg  <= cfg_wr_data[CAL_W-1:0];
                CFG_GRAVITY:     grav_reg <= cfg_wr_data[GRAV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                sum_reg[i]    <= '0;
                offset_reg[i] <= '0;
            end
        end else begin
            if (accum_we) begin
                sum_reg[axis_reg] <= alu_res;
            end
            if (offset_we) begin
                offset_reg[axis_reg] <= alu_res[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg[0] <= s_accel_x;
            sample_reg[1] <= s_accel_y;
            sample_reg[2] <= s_accel_z;
            sample_reg[3] <= s_gyro_x;
            sample_reg[4] <= s_gyro_y;
            sample_reg[5] <= s_gyro_z;
        end
        if (corr_we) begin
            out_reg[axis_reg] <= sat_res;
        end
    end

    imuoc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg[axis_reg]),
        .divisor  (samples_seen_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign m_valid        = m_valid_reg;
    assign m_corr_accel_x = out_reg[0];
    assign m_corr_accel_y = out_reg[1];
    assign m_corr_accel_z = out_reg[2];
    assign m_corr_gyro_x  = out_reg[3];
    assign m_corr_gyro_y  = out_reg[4];
    assign m_corr_gyro_z  = out_reg[5];

    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        calibrated_reg |=> calibrated_reg)
        else $error("calibrated flag dropped");

    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        calibrated_reg |=> $stable(samples_seen_reg))
        else $error("sample count moved after calibration");

    a_out_after_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> calibrated_reg)
        else $error("output word during calibration");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== rtl/core/imuoc_div.sv =====
`default_nettype none

module imuoc_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 10
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [DIVIDEND_W-1:0] dividend,
    input  wire logic        [DIVISOR_W-1:0]  divisor,
    output imuoc_pkg::div_stat_t              stat,
    output logic signed      [DIVIDEND_W-1:0] quotient
);
    import imuoc_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [STEP_W-1:0]     step_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // restoring divide on the magnitude, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && step_reg == STEP_W'(1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[DIVIDEND_W-1];
            quo_reg  <= dividend[DIVIDEND_W-1] ? -dividend : dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            step_reg <= STEP_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], fits};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // truncation toward zero: sign applied after the magnitude divide
    assign quotient  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import imuoc_pkg::*;

    localparam int COUNT_BITS    = 10;
    // last calibration word runs six divider passes; leave ample margin
    localparam int SETTLE_CYCLES = 6 * (COUNT_BITS + 19) + 200;
    localparam int PRINT_LIMIT   = 100;

    // axis a lives in bits [a*DATA_W +: DATA_W]; 0 = accel_x ... 5 = gyro_z
    typedef logic [AXES-1:0][DATA_W-1:0] sample_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_CAL_SAMPLES;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic signed [DATA_W-1:0] s_accel_x = '0;
    logic signed [DATA_W-1:0] s_accel_y = '0;
    logic signed [DATA_W-1:0] s_accel_z = '0;
    logic signed [DATA_W-1:0] s_gyro_x  = '0;
    logic signed [DATA_W-1:0] s_gyro_y  = '0;
    logic signed [DATA_W-1:0] s_gyro_z  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic signed [DATA_W-1:0] m_corr_accel_x;
    logic signed [DATA_W-1:0] m_corr_accel_y;
    logic signed [DATA_W-1:0] m_corr_accel_z;
    logic signed [DATA_W-1:0] m_corr_gyro_x;
    logic signed [DATA_W-1:0] m_corr_gyro_y;
    logic signed [DATA_W-1:0] m_corr_gyro_z;

    // predictor copy of registers and calibration state
    logic [CAL_W-1:0]      cal_samples_reg = CAL_RESET;
    logic [GRAV_W-1:0]     gravity_reg     = GRAV_RESET;
    longint                axis_sum [AXES];
    logic [COUNT_BITS-1:0] samples_taken   = '0;
    sample_t               axis_offset     = '0;
    bit                    calibrated      = 1'b0;

    sample_t               corrected_q [$];
    sample_t               got_word;
    sample_t               want_word;
    int                    error_count = 0;
    int unsigned           burst_left  = 1;
    int unsigned           ready_hold  = 0;
    string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z",
                                "gyro_x", "gyro_y", "gyro_z"};

    imu_offset_calibrate_correct_top #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accel_x     (s_accel_x),
        .s_accel_y     (s_accel_y),
        .s_accel_z     (s_accel_z),
        .s_gyro_x      (s_gyro_x),
        .s_gyro_y      (s_gyro_y),
        .s_gyro_z      (s_gyro_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_corr_accel_x(m_corr_accel_x),
        .m_corr_accel_y(m_corr_accel_y),
        .m_corr_accel_z(m_corr_accel_z),
        .m_corr_gyro_x (m_corr_gyro_x),
        .m_corr_gyro_y (m_corr_gyro_y),
        .m_corr_gyro_z (m_corr_gyro_z)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        for (int a = 0; a < AXES; a++) begin
            axis_sum[a] = 0;
        end
    end

    // Accumulates during calibration; afterwards returns the corrected word.
    function automatic bit predict_correction(input sample_t raw, output sample_t corr);
        int unsigned limit;
        int unsigned target;
        int unsigned taken;
        longint      quotient;
        int          diff;
        corr = '0;
        if (!calibrated) begin
            for (int a = 0; a < AXES; a++) begin
                axis_sum[a] = axis_sum[a] + $signed(raw[a]);
            end
            limit  = (1 << COUNT_BITS) - 1;
            target = (cal_samples_reg == 0) ? 1 : cal_samples_reg;
            if (target > limit) begin
                target = limit;
            end
            taken = samples_taken + 1;
            if (taken >= target) begin
                for (int a = 0; a < AXES; a++) begin
                    quotient = axis_sum[a] / longint'(taken);
                    axis_offset[a] = DATA_W'(quotient);
                    if (a == ACCEL_Z_AXIS) begin
                        axis_offset[a] = DATA_W'(quotient) - DATA_W'(gravity_reg);
                    end
                end
                calibrated = 1'b1;
            end
            samples_taken = taken[COUNT_BITS-1:0];
            return 1'b0;
        end
        for (int a = 0; a < AXES; a++) begin
            diff = $signed(raw[a]) - $signed(axis_offset[a]);
            if (diff > 32767) begin
                corr[a] = SAT_MAX;
            end else if (diff < -32768) begin
                corr[a] = SAT_MIN;
            end else begin
                corr[a] = DATA_W'(diff);
            end
        end
        return 1'b1;
    endfunction

    function automatic sample_t make_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz);
        return {DATA_W'(gz), DATA_W'(gy), DATA_W'(gx), DATA_W'(az), DATA_W'(ay), DATA_W'(ax)};
    endfunction

    function automatic logic [DATA_W-1:0] random_axis(input int a);
        logic [DATA_W-1:0] rail;
        // input that lands right at the saturation boundary for this offset
        rail = ($signed(axis_offset[a]) < 0) ? SAT_MAX + axis_offset[a]
                                              : SAT_MIN + axis_offset[a];
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return DATA_W'($urandom_range(0, 64)) - DATA_W'(32);
            3: return rail + DATA_W'($urandom_range(0, 4)) - DATA_W'(2);
            4: return axis_offset[a] + DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ERROR: %s", $time, what);
        end
    endtask

    // bursts of random length separated by random gaps, now and then a long run
    task automatic pace_sender();
        int unsigned gap;
        burst_left--;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_sample(input sample_t raw);
        sample_t corr;
        s_valid   <= 1'b1;
        s_accel_x <= raw[0];
        s_accel_y <= raw[1];
        s_accel_z <= raw[2];
        s_gyro_x  <= raw[3];
        s_gyro_y  <= raw[4];
        s_gyro_z  <= raw[5];
        do @(posedge aclk); while (!s_ready);
        if (predict_correction(raw, corr)) begin
            corrected_q.push_back(corr);
        end
        pace_sender();
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (corrected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CAL_SAMPLES: cal_samples_reg = CAL_W'(value);
            CFG_GRAVITY:     gravity_reg = GRAV_W'(value);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Calibration with extreme samples; the count is dropped to zero midway,
    // so the next word closes calibration over the samples actually taken.
    task automatic test_calibration();
        write_register(CFG_CAL_SAMPLES, 15'h03FF);
        write_register(CFG_GRAVITY, 0);
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(12000, -9000, -16384, -7, 250, -32768));
        send_sample(make_sample(20000, -20000, -16000, -3, 5000, -1000));
        send_sample(make_sample(3000, -3001, -5, 1, -1, 0));
        drain_results();
        // upper data bits set, cal_samples field zero
        write_register(CFG_CAL_SAMPLES, 15'h7C00);
        write_register(CFG_GRAVITY, 32767);
        send_sample(make_sample(7, -8, -8191, -32768, 32767, 123));
        drain_results();
    endtask

    task automatic test_correction_extremes();
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(axis_offset);
        send_sample({AXES{16'h5555}});
        send_sample({AXES{16'hAAAA}});
        send_sample(make_sample(1, -1, 1, -1, 1, -1));
        drain_results();
    endtask

    // once calibrated, register writes must leave the offsets alone
    task automatic test_config_after_calibration();
        write_register(CFG_CAL_SAMPLES, 1);
        write_register(CFG_GRAVITY, 0);
        send_sample(make_sample(100, -100, 4096, -4096, 32767, -32768));
        send_sample(make_sample(-1, 0, 1, 2, -2, 3));
        drain_results();
        write_register(CFG_CAL_SAMPLES, 15'h7FFF);
        write_register(CFG_GRAVITY, 15'h7FFF);
        send_sample(make_sample(-32768, 32767, -1, 0, 1, -2));
        send_sample(make_sample(555, -555, 20000, -20000, 7, -7));
        drain_results();
    endtask

    task automatic test_random_stream();
        sample_t raw;
        for (int chunk = 0; chunk < 4; chunk++) begin
            write_register(chunk[0] ? CFG_GRAVITY : CFG_CAL_SAMPLES, $urandom_range(0, 32767));
            for (int n = 0; n < 200; n++) begin
                for (int a = 0; a < AXES; a++) begin
                    raw[a] = random_axis(a);
                end
                send_sample(raw);
            end
            drain_results();
        end
    endtask

    // receiver: short stalls, ready runs of random length, sometimes long
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= !m_ready;
            if (m_ready) begin
                ready_hold <= $urandom_range(0, 8);
            end else if ($urandom_range(0, 9) == 0) begin
                ready_hold <= $urandom_range(100, 300);
            end else begin
                ready_hold <= $urandom_range(0, 20);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_word = {m_corr_gyro_z, m_corr_gyro_y, m_corr_gyro_x,
                        m_corr_accel_z, m_corr_accel_y, m_corr_accel_x};
            if (corrected_q.size() == 0) begin
                report_mismatch("corrected word with no sample pending");
            end else begin
                want_word = corrected_q.pop_front();
                for (int a = 0; a < AXES; a++) begin
                    if (got_word[a] !== want_word[a]) begin
                        report_mismatch($sformatf("corr_%s got %0d expected %0d", axis_name[a],
                                                  $signed(got_word[a]),
                                                  $signed(want_word[a])));
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_calibration();
        test_correction_extremes();
        test_config_after_calibration();
        test_random_stream();
        drain_results();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
